### src/rrss_pkg.sv
// shared types, constants and helpers for the round robin sleep scheduler
// no dependencies; imported by rrss_ctrl, rrss_dp and the top level
`default_nettype none

package rrss_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int SLICE_W   = 8;
  localparam int TICKS_W   = 16;
  localparam int RUN_W     = 8;
  localparam int ACTION_W  = 2;
  localparam int OUT_SLOT_W = 3;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd16;
  localparam logic [RUN_W-1:0]   RUN_MAX     = {RUN_W{1'b1}};

  // per-slot process state
  typedef enum logic [1:0] {
    SLOT_DEAD     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2,
    SLOT_BLOCKED  = 2'd3
  } slot_st_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_SLEEP = 2'd1,
    ACT_EXIT  = 2'd2,
    ACT_SPAWN = 2'd3
  } action_e;

  // datapath operations, one per controller step
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LATCH  = 3'd1,
    OP_ACTION = 3'd2,
    OP_SWEEP  = 3'd3,
    OP_CHECK  = 3'd4,
    OP_SEARCH = 3'd5,
    OP_INC    = 3'd6
  } dp_op_e;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'd0,
    FSM_ACTION = 3'd1,
    FSM_SWEEP  = 3'd2,
    FSM_CHECK  = 3'd3,
    FSM_SEARCH = 3'd4,
    FSM_INC    = 3'd5,
    FSM_DONE   = 3'd6
  } fsm_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic no_tick;      // sleep of zero ticks, nothing else happens
    logic sweep_last;   // sweep pointer on the last slot
    logic expired;      // current slot used its slice or is not running
    logic found;        // search pointer sits on a runnable slot
    logic search_last;  // last candidate of the round robin search
  } dp_stat_t;

  // next slot index with wrap-around
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(NUM_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/rrss_ctrl.sv
// sequencing state machine for the round robin sleep scheduler
// depends on rrss_pkg; drives rrss_dp through command and status structs
`default_nettype none

module rrss_ctrl
  import rrss_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     out_free_i,
  output logic          out_load_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = FSM_ACTION;
        end
      end
      FSM_ACTION: begin
        cmd_o.op = OP_ACTION;
        state_d  = stat_i.no_tick ? FSM_DONE : FSM_SWEEP;
      end
      FSM_SWEEP: begin
        cmd_o.op = OP_SWEEP;
        if (stat_i.sweep_last) begin
          state_d = FSM_CHECK;
        end
      end
      FSM_CHECK: begin
        cmd_o.op = OP_CHECK;
        state_d  = stat_i.expired ? FSM_SEARCH : FSM_INC;
      end
      FSM_SEARCH: begin
        cmd_o.op = OP_SEARCH;
        if (stat_i.found || stat_i.search_last) begin
          state_d = FSM_INC;
        end
      end
      FSM_INC: begin
        cmd_o.op = OP_INC;
        state_d  = FSM_DONE;
      end
      FSM_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/rrss_dp.sv
// slot table, pointers and time slice register of the round robin sleep scheduler
// depends on rrss_pkg; steered by rrss_ctrl, one slot table access per cycle
`default_nettype none

module rrss_dp
  import rrss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_stat_t                   stat_o,
  input  wire logic [ACTION_W-1:0]   action_i,
  input  wire logic [TICKS_W-1:0]    sleep_ticks_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [SLICE_W-1:0]    cfg_wdata_i,
  output logic [OUT_SLOT_W-1:0]      current_slot_o,
  output logic                       switched_o,
  output logic [OUT_SLOT_W-1:0]      new_slot_o,
  output logic                       new_ok_o
);

  slot_st_e             slot_state_q [NUM_SLOTS];
  logic [TICKS_W-1:0]   sleep_left_q [NUM_SLOTS];
  logic [RUN_W-1:0]     run_ticks_q  [NUM_SLOTS];

  logic [SLOT_W-1:0]    cur_q;
  logic [SLICE_W-1:0]   slice_q;
  action_e              action_q;
  logic [TICKS_W-1:0]   ticks_q;
  logic [SLOT_W-1:0]    idx_q;
  logic [SLOT_W-1:0]    cnt_q;
  logic                 sw_q;
  logic [SLOT_W-1:0]    new_slot_q;
  logic                 new_ok_q;

  // single table port
  logic [SLOT_W-1:0]    addr;
  slot_st_e             rd_st;
  logic [TICKS_W-1:0]   rd_sleep;
  logic [RUN_W-1:0]     rd_run;

  logic                 st_we, sl_we, rt_we;
  slot_st_e             st_wd;
  logic [TICKS_W-1:0]   sl_wd;
  logic [RUN_W-1:0]     rt_wd;
  logic                 claim;
  logic [NUM_SLOTS-1:0] running_vec;

  assign addr = (cmd_i.op == OP_SWEEP || cmd_i.op == OP_SEARCH) ? idx_q : cur_q;
  assign rd_st    = slot_state_q[addr];
  assign rd_sleep = sleep_left_q[addr];
  assign rd_run   = run_ticks_q[addr];

  assign claim = (action_q == ACT_SPAWN) && !new_ok_q && (rd_st == SLOT_DEAD);

  assign stat_o.no_tick     = (action_q == ACT_SLEEP) && (ticks_q == '0);
  assign stat_o.sweep_last  = (idx_q == SLOT_W'(NUM_SLOTS - 1));
  assign stat_o.expired     = (rd_run >= slice_q) || (rd_st != SLOT_RUNNING);
  assign stat_o.found       = (rd_st == SLOT_RUNNABLE);
  assign stat_o.search_last = (cnt_q == SLOT_W'(NUM_SLOTS - 1));

  // table write for this cycle
  always_comb begin
    st_we = 1'b0;
    sl_we = 1'b0;
    rt_we = 1'b0;
    st_wd = rd_st;
    sl_wd = rd_sleep;
    rt_wd = rd_run;
    case (cmd_i.op)
      OP_ACTION: begin
        if (action_q == ACT_SLEEP && ticks_q != '0) begin
          st_we = 1'b1;
          st_wd = SLOT_BLOCKED;
          sl_we = 1'b1;
          sl_wd = ticks_q;
        end else if (action_q == ACT_EXIT) begin
          st_we = 1'b1;
          st_wd = SLOT_DEAD;
        end
      end
      OP_SWEEP: begin
        if (claim) begin
          st_we = 1'b1;
          st_wd = SLOT_RUNNABLE;
          sl_we = 1'b1;
          sl_wd = '0;
          rt_we = 1'b1;
          rt_wd = '0;
        end else if (rd_st == SLOT_BLOCKED) begin
          sl_we = 1'b1;
          if (rd_sleep <= TICKS_W'(1)) begin
            sl_wd = '0;
            st_we = 1'b1;
            st_wd = SLOT_RUNNABLE;
          end else begin
            sl_wd = rd_sleep - TICKS_W'(1);
          end
        end
      end
      OP_CHECK: begin
        // demote a running slot whose slice is used up
        if (stat_o.expired && rd_st == SLOT_RUNNING) begin
          st_we = 1'b1;
          st_wd = SLOT_RUNNABLE;
          rt_we = 1'b1;
          rt_wd = '0;
        end
      end
      OP_SEARCH: begin
        if (stat_o.found) begin
          st_we = 1'b1;
          st_wd = SLOT_RUNNING;
          rt_we = 1'b1;
          rt_wd = '0;
        end
      end
      OP_INC: begin
        if (rd_run != RUN_MAX) begin
          rt_we = 1'b1;
          rt_wd = rd_run + RUN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_state_q[i] <= (i == 0) ? SLOT_RUNNING : SLOT_DEAD;
        sleep_left_q[i] <= '0;
        run_ticks_q[i]  <= '0;
      end
    end else begin
      if (st_we) begin
        slot_state_q[addr] <= st_wd;
      end
      if (sl_we) begin
        sleep_left_q[addr] <= sl_wd;
      end
      if (rt_we) begin
        run_ticks_q[addr] <= rt_wd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      slice_q <= SLICE_RESET;
    end else begin
      if (cfg_we_i) begin
        slice_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_SEARCH && stat_o.found) begin
        cur_q <= idx_q;
      end
    end
  end

  // item scratch and result fields
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        action_q   <= action_e'(action_i);
        ticks_q    <= sleep_ticks_i;
        idx_q      <= '0;
        sw_q       <= 1'b0;
        new_slot_q <= '0;
        new_ok_q   <= 1'b0;
      end
      OP_SWEEP: begin
        idx_q <= next_slot(idx_q);
        if (claim) begin
          new_slot_q <= idx_q;
          new_ok_q   <= 1'b1;
        end
      end
      OP_CHECK: begin
        idx_q <= next_slot(cur_q);
        cnt_q <= SLOT_W'(1);
      end
      OP_SEARCH: begin
        idx_q <= next_slot(idx_q);
        cnt_q <= cnt_q + SLOT_W'(1);
        if (stat_o.found) begin
          sw_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign current_slot_o = OUT_SLOT_W'(cur_q);
  assign switched_o     = sw_q;
  assign new_slot_o     = OUT_SLOT_W'(new_slot_q);
  assign new_ok_o       = new_ok_q;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      running_vec[i] = (slot_state_q[i] == SLOT_RUNNING);
    end
  end

  a_one_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(running_vec))
    else $error("more than one slot running");

  a_running_is_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running_vec == '0) || running_vec[cur_q])
    else $error("running slot is not the current slot");

  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= SLOT_W'(NUM_SLOTS - 1))
    else $error("current slot index out of range");

  a_switch_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sw_q) |-> $past(cmd_i.op == OP_SEARCH))
    else $error("switch flag set outside the search");

endmodule

`default_nettype wire

### src/round_robin_sleep_scheduler_unit.sv
// top level of the round robin sleep scheduler: stream ports and result register
// depends on rrss_pkg, rrss_ctrl and rrss_dp
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  action [1:0], sleep_ticks [17:2]
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  current_slot, switched, new_slot, new_ok
// cfg       in   cfg_we_i                         time_slice [7:0]
//
// one transaction in gives one transaction out; items are handled one at a time
// the time per item is set by the countdown sweep and the round robin search, one
// slot per cycle on the single slot table port; a sleep of zero ticks skips the
// sweep, the check, the search and the run tick increment
// reset: slot 0 running and current, all others dead, time slice 16
// a stalled output holds its result; the next input transaction is taken as soon
// as the previous result sits in the output register
`default_nettype none

module round_robin_sleep_scheduler_unit
  import rrss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // action [1:0], sleep_ticks [17:2], zero pad
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // current_slot [2:0], switched [3],
                                             // new_slot [6:4], new_ok [7]
  // time slice register
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic                   out_free;
  logic                   out_load;

  logic [OUT_SLOT_W-1:0]  current_slot;
  logic                   switched;
  logic [OUT_SLOT_W-1:0]  new_slot;
  logic                   new_ok;

  logic                   m_valid_q;
  logic [7:0]             m_data_q;

  // output register is free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready_i;

  rrss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrss_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (s_axis_tdata_i[1:0]),
    .sleep_ticks_i  (s_axis_tdata_i[17:2]),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .current_slot_o (current_slot),
    .switched_o     (switched),
    .new_slot_o     (new_slot),
    .new_ok_o       (new_ok)
  );

  // result holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {new_ok, new_slot, switched, current_slot};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire
